[hw/rtl/spa_pkg.sv]
// ----------------------------------------------------------------------------
// spa_pkg: shared types and constants for the sorted pending address set
// Holds the capacity, the result status codes and the command that the
// controller broadcasts to every cell of the chain.
// ----------------------------------------------------------------------------
package spa_pkg;

  localparam int CAPACITY = 16;
  localparam int OFF_W    = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int STAT_W   = 3;
  localparam int HELD_W   = 5;

  localparam logic [STAT_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STAT_W-1:0] ST_DUPLICATE = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STAT_W-1:0] ST_POPPED    = 3'd3;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd4;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_POP    = 1'b1;

  // Command broadcast to all cells at once.
  typedef struct packed {
    logic             cmp_en;  // capture compare flags against val
    logic             ins_en;  // insert val at its sorted place
    logic             pop_en;  // shift every entry down by one cell
    logic [OFF_W-1:0] val;
  } cmd_t;

endpackage

[hw/rtl/spa_cell.sv]
// ----------------------------------------------------------------------------
// spa_cell: one storage cell of the sorted chain
// Holds one offset and its valid bit, registers its compare flags, and on an
// insert or pop takes its new contents from a neighboring cell or the new value.
// ----------------------------------------------------------------------------
module spa_cell (
  input  logic                    clk,
  input  logic                    rst_n,
  input  spa_pkg::cmd_t           cmd,
  input  logic                    prev_valid,
  input  logic                    prev_gt,
  input  logic [spa_pkg::OFF_W-1:0] prev_off,
  input  logic                    next_valid,
  input  logic [spa_pkg::OFF_W-1:0] next_off,
  output logic                    valid,
  output logic                    gt,
  output logic                    eq,
  output logic [spa_pkg::OFF_W-1:0] off
);
  import spa_pkg::*;

  logic             valid_r, valid_nxt;
  logic [OFF_W-1:0] off_r, off_nxt;
  logic             gt_r, eq_r;
  logic             take_left;

  // On an insert a cell takes new contents when its entry is larger than the
  // new value, or when it is the first free cell: the left entry if larger, else the value.
  assign take_left = gt_r || (!valid_r && prev_valid);

  always_comb begin
    valid_nxt = valid_r;
    off_nxt   = off_r;
    if (cmd.ins_en && take_left) begin
      valid_nxt = 1'b1;
      off_nxt   = prev_gt ? prev_off : cmd.val;
    end else if (cmd.pop_en) begin
      valid_nxt = next_valid;
      off_nxt   = next_valid ? next_off : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      gt_r    <= 1'b0;
      eq_r    <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      if (cmd.cmp_en) begin
        gt_r <= valid_r && (off_r > cmd.val);
        eq_r <= valid_r && (off_r == cmd.val);
      end
    end
  end

  always_ff @(posedge clk) begin
    off_r <= off_nxt;
  end

  assign valid = valid_r;
  assign gt    = gt_r;
  assign eq    = eq_r;
  assign off   = off_r;

endmodule

[hw/rtl/sorted_pending_address_set_unit.sv]
// ----------------------------------------------------------------------------
// sorted_pending_address_set_unit: sorted worklist of pending offsets
// A chain of cells keeps distinct 16-bit offsets in ascending order. Inserts
// skip duplicates and drop into a full set; pops return the smallest offset.
// ----------------------------------------------------------------------------
//
//  Channel  Ports                                        Handshake
//  -------  -------------------------------------------  -----------------------
//  request  in_kind, in_target_offset                    start high, busy low
//  result   out_status, out_popped_offset,               out_strobe, one cycle
//           out_held_count
//
// Every request is accepted in idle, then passes a compare state in which
// every cell compares its entry against the offset and registers the result,
// and an update state in which the duplicate check (an OR over all cell
// flags) or the empty check decides the operation and cells shift at once.
// The result strobe appears in the cycle after the update, and busy is
// already low in that cycle, so the next request is accepted while the
// result is shown. Reset empties the set at once; no clearing pass is needed.
// The receiver cannot stall, so nothing holds the result back.
// ----------------------------------------------------------------------------
module sorted_pending_address_set_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_kind,
  input  logic [spa_pkg::OFF_W-1:0]    in_target_offset,
  output logic                         out_strobe,
  output logic [spa_pkg::STAT_W-1:0]   out_status,
  output logic [spa_pkg::OFF_W-1:0]    out_popped_offset,
  output logic [spa_pkg::HELD_W-1:0]   out_held_count
);
  import spa_pkg::*;

  // Controller states.
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic              kind_r;
  logic [OFF_W-1:0]  val_r;
  logic [CNT_W-1:0]  count_r, count_nxt;

  logic              strobe_r;
  logic [STAT_W-1:0] status_r, status_nxt;
  logic [OFF_W-1:0]  popped_r, popped_nxt;

  logic              accept;
  cmd_t              cmd;

  // Chain signals. Index 0 is the smallest entry.
  logic [CAPACITY-1:0] valid_vec, gt_vec, eq_vec;
  logic [OFF_W-1:0]    off_vec [CAPACITY];

  logic dup, full, empty;

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);

  // The flags were captured in the compare cycle, so the duplicate test is a
  // plain OR over registered bits.
  assign dup   = |eq_vec;
  assign full  = (count_r == CNT_W'(CAPACITY));
  assign empty = (count_r == '0);

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    status_nxt = ST_INSERTED;
    popped_nxt = '0;
    cmd.cmp_en = 1'b0;
    cmd.ins_en = 1'b0;
    cmd.pop_en = 1'b0;
    cmd.val    = val_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        cmd.cmp_en = 1'b1;
        state_nxt  = S_UPD;
      end
      S_UPD: begin
        state_nxt = S_IDLE;
        if (kind_r == KIND_INSERT) begin
          // A duplicate is reported ahead of a full set.
          if (dup) begin
            status_nxt = ST_DUPLICATE;
          end else if (full) begin
            status_nxt = ST_FULL;
          end else begin
            status_nxt = ST_INSERTED;
            cmd.ins_en = 1'b1;
            count_nxt  = count_r + 1'b1;
          end
        end else begin
          if (empty) begin
            status_nxt = ST_EMPTY;
          end else begin
            status_nxt = ST_POPPED;
            popped_nxt = off_vec[0];
            cmd.pop_en = 1'b1;
            count_nxt  = count_r - 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      strobe_r <= (state_r == S_UPD);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r <= in_kind;
      val_r  <= in_target_offset;
    end
    if (state_r == S_UPD) begin
      status_r <= status_nxt;
      popped_r <= popped_nxt;
    end
  end

  // The cell chain. The left end acts as an always-valid cell that never
  // holds a larger entry; the right end acts as an empty cell.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic             p_valid, p_gt, n_valid;
    logic [OFF_W-1:0] p_off, n_off;

    if (i == 0) begin : g_left
      assign p_valid = 1'b1;
      assign p_gt    = 1'b0;
      assign p_off   = '0;
    end else begin : g_mid
      assign p_valid = valid_vec[i-1];
      assign p_gt    = gt_vec[i-1];
      assign p_off   = off_vec[i-1];
    end

    if (i == CAPACITY - 1) begin : g_right
      assign n_valid = 1'b0;
      assign n_off   = '0;
    end else begin : g_inner
      assign n_valid = valid_vec[i+1];
      assign n_off   = off_vec[i+1];
    end

    spa_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .prev_valid (p_valid),
      .prev_gt    (p_gt),
      .prev_off   (p_off),
      .next_valid (n_valid),
      .next_off   (n_off),
      .valid      (valid_vec[i]),
      .gt         (gt_vec[i]),
      .eq         (eq_vec[i]),
      .off        (off_vec[i])
    );
  end

  assign out_strobe        = strobe_r;
  assign out_status        = status_r;
  assign out_popped_offset = popped_r;
  assign out_held_count    = HELD_W'(count_r);

`ifndef SYNTH
  // The held count never passes the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("held count above capacity");

  // The count agrees with the number of valid cells.
  a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_vec) == int'(count_r))
    else $error("held count disagrees with valid cells");

  // Valid cells always form a block at the low end of the chain.
  a_packed: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_vec & (valid_vec + 1'b1)) == '0)
    else $error("valid cells are not packed at the low end");

  // Every update cycle is followed by a result strobe.
  a_strobe_after_upd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD) |=> out_strobe)
    else $error("update cycle without a result");

  // The set changes only in an update cycle.
  a_stable_outside_upd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_UPD) |=> $stable(count_r))
    else $error("held count changed outside an update");
`endif

endmodule
